### design/odht_pkg.sv
package odht_pkg;

  localparam int NUM_TABLES = 8;
  localparam int TBL_BITS   = $clog2(NUM_TABLES);
  localparam int SLOTS      = 1024;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int SIZE_BITS  = SLOT_BITS + 1;
  localparam int KEY_BITS   = 16;
  localparam int ADDR_BITS  = TBL_BITS + SLOT_BITS;
  localparam int MEM_DEPTH  = NUM_TABLES * SLOTS;
  localparam int CFG_BITS   = 11;

  localparam logic [CFG_BITS-1:0] SIZE_RESET = CFG_BITS'(1021);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_DELETED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Probe step (key mod 7) + 1. Since 8 = 1 mod 7, the octal digits of the
  // key are summed and folded until the value is at most 7.
  function automatic logic [3:0] probe_step(input logic [KEY_BITS-1:0] k);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 6'(k[2:0]) + 6'(k[5:3]) + 6'(k[8:6]) + 6'(k[11:9]) + 6'(k[14:12])
       + 6'(k[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 3'(s2[2:0] + 3'(s2[3]));
    if (s3 == 3'd7) begin
      s3 = 3'd0;
    end
    return 4'(s3) + 4'd1;
  endfunction

endpackage

### design/odht_ram.sv
module odht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/odht_mod.sv
module odht_mod
  import odht_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [KEY_BITS-1:0]  dividend_i,
  input  logic [SIZE_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [SIZE_BITS-1:0] rem_o
);

  localparam int CNT_BITS = $clog2(KEY_BITS + 1);

  logic                 busy_q, busy_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [KEY_BITS-1:0]  dvd_q, dvd_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;
  logic [SIZE_BITS:0]   shifted;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[KEY_BITS-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(KEY_BITS);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (shifted >= {1'b0, divisor_i}) begin
          rem_d = SIZE_BITS'(shifted - {1'b0, divisor_i});
        end else begin
          rem_d = SIZE_BITS'(shifted);
        end
        dvd_d = {dvd_q[KEY_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

### design/ordered_double_hash_table.sv
// Ordered double-hash tables: eight open-addressed tables, each of
// table_size slots (a prime, limited to 1024), held in one slot memory with
// a used bit and a key per slot. After reset the block clears all 8192 slots
// and accepts no item meanwhile. An item first finds its start position (a
// bit-serial key mod size); every probe is then a read, a check with
// write-back and a step, and each wrap of the step past the end of the table
// is one more subtraction of the size. An insert into a full table skips the
// hash and the walk. An insert whose walk runs out restores its swapped slots
// from a journal, a read and a write per swap. The result sits in an output
// register, so the next item is accepted while it waits. The user must write
// table_size only while the block is idle; the block does not enforce it.
module ordered_double_hash_table
  import odht_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [23:0]         s_axis_tdata_i,   // table_index[2:0], key[18:3]
  input  logic                s_axis_tuser_i,   // operation[0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o,   // probe_count[10:0]
  output logic [1:0]          m_axis_tuser_o    // status[1:0]
);

  localparam int JRN_WIDTH = SLOT_BITS + KEY_BITS;
  localparam int SLOT_WIDTH = KEY_BITS + 1;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HASH     = 4'd2;
  localparam logic [3:0] S_READ     = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_STEP     = 4'd5;
  localparam logic [3:0] S_UNDO_RD  = 4'd6;
  localparam logic [3:0] S_UNDO_WR  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [CFG_BITS-1:0]  table_size_q;
  logic [SIZE_BITS-1:0] size;
  logic [ADDR_BITS:0]   clr_q, clr_d;
  logic                 op_q, op_d;
  logic [TBL_BITS-1:0]  tbl_q, tbl_d;
  logic [KEY_BITS-1:0]  carry_q, carry_d;
  logic [SLOT_BITS-1:0] pos_q, pos_d;
  logic [SIZE_BITS-1:0] sum_q, sum_d;
  logic [SIZE_BITS-1:0] n_q, n_d;
  logic [SIZE_BITS-1:0] jn_q, jn_d;
  logic [1:0]           res_status_q, res_status_d;
  logic [SIZE_BITS-1:0] res_count_q, res_count_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [SIZE_BITS-1:0] out_count_q, out_count_d;
  logic [SIZE_BITS-1:0] occ_q [NUM_TABLES];
  logic                 occ_inc, occ_dec;

  logic                  in_xfer;
  logic [TBL_BITS-1:0]   in_tbl;
  logic [KEY_BITS-1:0]   in_key;
  logic                  div_start, div_done;
  logic [SIZE_BITS-1:0]  div_rem;

  logic                  slot_we, slot_re;
  logic [ADDR_BITS-1:0]  slot_waddr, slot_raddr;
  logic [SLOT_WIDTH-1:0] slot_wdata, slot_rdata;
  logic                  jrn_we, jrn_re;
  logic [SLOT_BITS-1:0]  jrn_raddr;
  logic [JRN_WIDTH-1:0]  jrn_wdata, jrn_rdata;

  logic                  cur_used;
  logic [KEY_BITS-1:0]   cur_key;
  logic [SIZE_BITS-1:0]  n_next;
  logic [KEY_BITS-1:0]   new_carry;

  always_comb begin
    size = SIZE_BITS'(table_size_q);
    if (table_size_q == '0) begin
      size = SIZE_BITS'(1);
    end else if (table_size_q > CFG_BITS'(SLOTS)) begin
      size = SIZE_BITS'(SLOTS);
    end
  end

  assign in_tbl   = s_axis_tdata_i[TBL_BITS-1:0];
  assign in_key   = s_axis_tdata_i[TBL_BITS +: KEY_BITS];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;

  assign cur_used  = slot_rdata[KEY_BITS];
  assign cur_key   = slot_rdata[KEY_BITS-1:0];
  assign n_next    = n_q + SIZE_BITS'(1);
  assign new_carry = (cur_key > carry_q) ? cur_key : carry_q;

  odht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_key),
    .divisor_i  (size),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  odht_ram #(
    .WIDTH (SLOT_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Journal of the slots an insert has swapped, used to restore the table
  // when the walk finds no empty slot.
  odht_ram #(
    .WIDTH (JRN_WIDTH),
    .DEPTH (SLOTS)
  ) u_journal (
    .clk_i   (clk_i),
    .we_i    (jrn_we),
    .waddr_i (jn_q[SLOT_BITS-1:0]),
    .wdata_i (jrn_wdata),
    .re_i    (jrn_re),
    .raddr_i (jrn_raddr),
    .rdata_o (jrn_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    tbl_d        = tbl_q;
    carry_d      = carry_q;
    pos_d        = pos_q;
    sum_d        = sum_q;
    n_d          = n_q;
    jn_d         = jn_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    occ_inc      = 1'b0;
    occ_dec      = 1'b0;
    div_start    = 1'b0;
    slot_we      = 1'b0;
    slot_waddr   = {tbl_q, pos_q};
    slot_wdata   = {1'b1, carry_q};
    slot_re      = 1'b0;
    slot_raddr   = {tbl_q, pos_q};
    jrn_we       = 1'b0;
    jrn_wdata    = {pos_q, cur_key};
    jrn_re       = 1'b0;
    jrn_raddr    = SLOT_BITS'(jn_q - SIZE_BITS'(1));

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q[ADDR_BITS-1:0];
        slot_wdata = '0;
        clr_d      = clr_q + (ADDR_BITS+1)'(1);
        if (clr_q == (ADDR_BITS+1)'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_d    = s_axis_tuser_i;
          tbl_d   = in_tbl;
          carry_d = in_key;
          n_d     = '0;
          jn_d    = '0;
          if (s_axis_tuser_i == OP_INSERT && occ_q[in_tbl] >= size) begin
            res_status_d = ST_FULL;
            res_count_d  = '0;
            state_d      = S_DONE;
          end else begin
            div_start = 1'b1;
            state_d   = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (div_done) begin
          pos_d   = div_rem[SLOT_BITS-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        slot_re = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        n_d = n_next;
        if (op_q == OP_INSERT) begin
          if (!cur_used) begin
            slot_we      = 1'b1;
            occ_inc      = 1'b1;
            res_status_d = ST_INSERTED;
            res_count_d  = n_next;
            state_d      = S_DONE;
          end else begin
            // The slot keeps the smaller key; the larger one walks on.
            if (cur_key > carry_q) begin
              slot_we = 1'b1;
              jrn_we  = 1'b1;
              jn_d    = jn_q + SIZE_BITS'(1);
            end
            carry_d = new_carry;
            sum_d   = {1'b0, pos_q} + SIZE_BITS'(probe_step(new_carry));
            if (n_next == size) begin
              res_status_d = ST_FULL;
              res_count_d  = n_next;
              state_d      = S_UNDO_RD;
            end else begin
              state_d = S_STEP;
            end
          end
        end else begin
          if (cur_used && cur_key == carry_q) begin
            slot_we      = 1'b1;
            slot_wdata   = {1'b0, cur_key};
            occ_dec      = 1'b1;
            res_status_d = ST_DELETED;
            res_count_d  = n_next;
            state_d      = S_DONE;
          end else begin
            sum_d = {1'b0, pos_q} + SIZE_BITS'(probe_step(carry_q));
            if (n_next == size) begin
              res_status_d = ST_NOT_FOUND;
              res_count_d  = n_next;
              state_d      = S_DONE;
            end else begin
              state_d = S_STEP;
            end
          end
        end
      end
      S_STEP: begin
        if (sum_q >= size) begin
          sum_d = sum_q - size;
        end else begin
          pos_d   = sum_q[SLOT_BITS-1:0];
          state_d = S_READ;
        end
      end
      S_UNDO_RD: begin
        // Swaps are undone newest first, so a slot swapped twice ends with
        // its original key.
        if (jn_q == '0) begin
          state_d = S_DONE;
        end else begin
          jrn_re  = 1'b1;
          jn_d    = jn_q - SIZE_BITS'(1);
          state_d = S_UNDO_WR;
        end
      end
      S_UNDO_WR: begin
        slot_we    = 1'b1;
        slot_waddr = {tbl_q, jrn_rdata[JRN_WIDTH-1:KEY_BITS]};
        slot_wdata = {1'b1, jrn_rdata[KEY_BITS-1:0]};
        state_d    = S_UNDO_RD;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_count_d  = res_count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      table_size_q <= SIZE_RESET;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        occ_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        table_size_q <= cfg_wdata_i;
      end
      if (occ_inc) begin
        occ_q[tbl_q] <= occ_q[tbl_q] + SIZE_BITS'(1);
      end else if (occ_dec && occ_q[tbl_q] != '0) begin
        occ_q[tbl_q] <= occ_q[tbl_q] - SIZE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tbl_q        <= tbl_d;
    carry_q      <= carry_d;
    pos_q        <= pos_d;
    sum_q        <= sum_d;
    n_q          <= n_d;
    jn_q         <= jn_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {(16 - SIZE_BITS)'(0), out_count_q};

endmodule
